// ===== rtl/core/matrix3x3_inverse_adjugate_top_defines.svh =====
// Assertion macros for the 3x3 inverse block.
`ifndef MATRIX3X3_INVERSE_ADJUGATE_TOP_DEFINES_SVH
`define MATRIX3X3_INVERSE_ADJUGATE_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define MIA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mia: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define MIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mia: next-cycle check failed");

// Next-cycle implication, live during reset.
`define MIA_ASSERT_NEXT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mia: reset check failed");

`endif

// ===== rtl/core/mia_pkg.sv =====
package mia_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ENT_W      = 32;
   localparam int N_ENT      = 9;
   localparam int N_COL      = 3;
   localparam int COF_W      = 2 * ENT_W;
   localparam int DET_W      = 98;
   localparam int DMAG_W     = DET_W - 1;
   localparam int REM_W      = DET_W;
   localparam int NUM_W      = COF_W + 2 * FRAC_BITS;
   localparam int HEAD_W     = NUM_W - ENT_W;
   localparam int DIV_STEPS  = ENT_W;
   localparam int IN_DATA_W  = N_ENT * ENT_W;
   localparam int OUT_DATA_W = N_ENT * ENT_W;
   localparam int USER_W     = 2;
   localparam int USER_SINGULAR = 0;
   localparam int USER_SAT      = 1;

   localparam logic [ENT_W-1:0] POS_MAX = {1'b0, {(ENT_W-1){1'b1}}};
   localparam logic [ENT_W-1:0] NEG_MIN = {1'b1, {(ENT_W-1){1'b0}}};

   // cofactor k = m[AX]*m[AY] - m[BX]*m[BY], entries flat row-major
   localparam int unsigned AX [N_ENT] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
   localparam int unsigned AY [N_ENT] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
   localparam int unsigned BX [N_ENT] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
   localparam int unsigned BY [N_ENT] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};
   // transpose: result entry k takes cofactor TR[k]
   localparam int unsigned TR [N_ENT] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

   typedef logic signed [ENT_W-1:0] ent_type;
   typedef logic signed [COF_W-1:0] cof_type;
   typedef logic signed [DET_W-1:0] det_type;
   typedef ent_type [N_ENT-1:0] mat_type;
   typedef cof_type [N_ENT-1:0] cofs_type;
   typedef ent_type [N_COL-1:0] row_type;

   typedef struct packed {
      row_type  row0;
      cofs_type cof;
   } cof_item_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [ENT_W-1:0] lq;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type [N_ENT-1:0] lane;
      logic [DMAG_W-1:0]    dmag;
      logic                 singular;
   } div_item_type;

endpackage

// ===== rtl/core/mia_cof.sv =====
module mia_cof (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mia_pkg::mat_type      in_mat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mia_pkg::cof_item_type out_item
);
   import mia_pkg::*;

   logic [2:0]   vld_ff;
   logic [2:0]   rdy;
   mat_type      m_ff;
   cofs_type     pa_in, pb_in, pa_ff, pb_ff;
   row_type      r1_ff;
   cof_item_type item_in, item_ff;

   always_comb begin
      rdy[2] = !vld_ff[2] || out_ready;
      rdy[1] = !vld_ff[1] || rdy[2];
      rdy[0] = !vld_ff[0] || rdy[1];
   end
   assign in_ready = rdy[0];

   for (genvar k = 0; k < N_ENT; k++) begin : g_prod
      assign pa_in[k] = $signed(m_ff[AX[k]]) * $signed(m_ff[AY[k]]);
      assign pb_in[k] = $signed(m_ff[BX[k]]) * $signed(m_ff[BY[k]]);
      assign item_in.cof[k] = $signed(pa_ff[k]) - $signed(pb_ff[k]);
   end
   assign item_in.row0 = r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         if (rdy[1]) vld_ff[1] <= vld_ff[0];
         if (rdy[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) m_ff <= in_mat;
      if (rdy[1] && vld_ff[0]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         r1_ff <= m_ff[N_COL-1:0];
      end
      if (rdy[2] && vld_ff[1]) item_ff <= item_in;
   end

   assign out_valid = vld_ff[2];
   assign out_item  = item_ff;

endmodule

// ===== rtl/core/mia_det.sv =====
module mia_det (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mia_pkg::cof_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mia_pkg::div_item_type out_item
);
   import mia_pkg::*;

   localparam int NST = 5;

   logic [NST-1:0]            vld_ff;
   logic [NST-1:0]            rdy;
   logic [NST-1:0]            src_vld;

   logic signed [COF_W-1:0]   ph_in [N_COL];
   logic signed [COF_W:0]     pl_in [N_COL];
   logic signed [COF_W-1:0]   ph_ff [N_COL];
   logic signed [COF_W:0]     pl_ff [N_COL];
   cofs_type                  cof0_ff, cof1_ff, cof2_ff;
   det_type                   prod_in [N_COL];
   det_type                   prod_ff [N_COL];
   det_type                   det_in, det_ff;
   logic [DMAG_W-1:0]         dmag_in, dmag_ff;
   logic                      sing_in, sing_ff;
   logic [COF_W-1:0]          cmag_in [N_ENT];
   logic [COF_W-1:0]          cmag_ff [N_ENT];
   logic [N_ENT-1:0]          neg_in, neg_ff;
   logic [NUM_W-1:0]          num [N_ENT];
   div_item_type              item_in, item_ff;

   always_comb begin
      rdy[NST-1] = !vld_ff[NST-1] || out_ready;
      for (int s = NST - 2; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end
   assign src_vld  = {vld_ff[NST-2:0], in_valid};
   assign in_ready = rdy[0];

   for (genvar j = 0; j < N_COL; j++) begin : g_pp
      assign ph_in[j] = $signed(in_item.row0[j]) * $signed(in_item.cof[j][COF_W-1:ENT_W]);
      assign pl_in[j] = $signed(in_item.row0[j]) * $signed({1'b0, in_item.cof[j][ENT_W-1:0]});
      assign prod_in[j] = (DET_W'(ph_ff[j]) <<< ENT_W) + DET_W'(pl_ff[j]);
   end

   assign det_in  = prod_ff[0] + prod_ff[1] + prod_ff[2];
   assign dmag_in = DMAG_W'(det_ff[DET_W-1] ? -det_ff : det_ff);
   assign sing_in = (det_ff == '0);

   for (genvar k = 0; k < N_ENT; k++) begin : g_lane
      assign cmag_in[k] = cof2_ff[TR[k]][COF_W-1] ? COF_W'(-cof2_ff[TR[k]]) : cof2_ff[TR[k]];
      assign neg_in[k]  = cof2_ff[TR[k]][COF_W-1] ^ det_ff[DET_W-1];
      assign num[k]     = NUM_W'(cmag_ff[k]) << (2 * FRAC_BITS);
      assign item_in.lane[k].rem = REM_W'(num[k][NUM_W-1:ENT_W]);
      assign item_in.lane[k].lq  = num[k][ENT_W-1:0];
      assign item_in.lane[k].neg = neg_ff[k];
      assign item_in.lane[k].ovf = REM_W'(num[k][NUM_W-1:ENT_W]) >= REM_W'(dmag_ff);
   end
   assign item_in.dmag     = dmag_ff;
   assign item_in.singular = sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NST; s++) begin
            if (rdy[s]) vld_ff[s] <= src_vld[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && src_vld[0]) begin
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         cof0_ff <= in_item.cof;
      end
      if (rdy[1] && src_vld[1]) begin
         prod_ff <= prod_in;
         cof1_ff <= cof0_ff;
      end
      if (rdy[2] && src_vld[2]) begin
         det_ff  <= det_in;
         cof2_ff <= cof1_ff;
      end
      if (rdy[3] && src_vld[3]) begin
         dmag_ff <= dmag_in;
         sing_ff <= sing_in;
         cmag_ff <= cmag_in;
         neg_ff  <= neg_in;
      end
      if (rdy[4] && src_vld[4]) item_ff <= item_in;
   end

   assign out_valid = vld_ff[NST-1];
   assign out_item  = item_ff;

endmodule

// ===== rtl/core/mia_div.sv =====
module mia_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mia_pkg::div_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mia_pkg::div_item_type out_item
);
   import mia_pkg::*;

   logic [DIV_STEPS-1:0] vld_ff;
   logic [DIV_STEPS-1:0] rdy;
   logic [DIV_STEPS-1:0] src_vld;
   div_item_type         src   [DIV_STEPS];
   div_item_type         st_ff [DIV_STEPS];

   // one restoring step per lane: one quotient bit
   function automatic div_item_type div_step(div_item_type x);
      div_item_type     y;
      logic [REM_W-1:0] t;
      logic             ge;
      y = x;
      for (int k = 0; k < N_ENT; k++) begin
         t  = {x.lane[k].rem[REM_W-2:0], x.lane[k].lq[ENT_W-1]};
         ge = (t >= REM_W'(x.dmag));
         y.lane[k].rem = ge ? (t - REM_W'(x.dmag)) : t;
         y.lane[k].lq  = {x.lane[k].lq[ENT_W-2:0], ge};
      end
      return y;
   endfunction

   always_comb begin
      rdy[DIV_STEPS-1] = !vld_ff[DIV_STEPS-1] || out_ready;
      for (int s = DIV_STEPS - 2; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end
   assign src_vld  = {vld_ff[DIV_STEPS-2:0], in_valid};
   assign in_ready = rdy[0];

   always_comb begin
      src[0] = in_item;
      for (int s = 1; s < DIV_STEPS; s++) begin
         src[s] = st_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            if (rdy[s]) vld_ff[s] <= src_vld[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (rdy[s] && src_vld[s]) st_ff[s] <= div_step(src[s]);
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_item  = st_ff[DIV_STEPS-1];

endmodule

// ===== rtl/core/matrix3x3_inverse_adjugate_top.sv =====
// channel   dir  tdata                          tuser
// req_      in   a00..a22, 32b each, a00 low    -
// rsp_      out  inv00..inv22, 32b each, low up  [0] singular, [1] saturated
//
// One matrix per cycle sustained while rsp_tready stays high; most stages are in the 32-step
// restoring divider (one quotient bit per stage, nine lanes side by side).
// Synchronous reset clears every valid bit; payload registers are not reset.
// A stall on rsp_tready fills empty stages first, then backs up to req_tready.
module matrix3x3_inverse_adjugate_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mia_pkg::IN_DATA_W-1:0]    req_tdata,   // a00 .. a22
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mia_pkg::OUT_DATA_W-1:0]   rsp_tdata,   // inv00 .. inv22
   output logic [mia_pkg::USER_W-1:0]       rsp_tuser    // singular, saturated
);
   import mia_pkg::*;

   mat_type                in_mat;
   logic                   cof_valid, cof_ready;
   cof_item_type           cof_item;
   logic                   det_valid, det_ready;
   div_item_type           det_item;
   logic                   div_valid, div_ready;
   div_item_type           div_item;

   logic                   rsp_tvalid_ff;
   logic [OUT_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [USER_W-1:0]      rsp_tuser_ff, rsp_tuser_in;
   logic [N_ENT-1:0]       sat;

   assign in_mat = mat_type'(req_tdata);

   mia_cof u_cof (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mat    (in_mat),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_item  (cof_item)
   );

   mia_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_item   (cof_item),
      .out_valid (det_valid),
      .out_ready (det_ready),
      .out_item  (det_item)
   );

   mia_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (det_valid),
      .in_ready  (det_ready),
      .in_item   (det_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item)
   );

   assign div_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      for (int k = 0; k < N_ENT; k++) begin
         if (div_item.lane[k].neg) begin
            sat[k] = div_item.lane[k].ovf
                     || (div_item.lane[k].lq[ENT_W-1] && (|div_item.lane[k].lq[ENT_W-2:0]));
            rsp_tdata_in[k*ENT_W +: ENT_W] = sat[k] ? NEG_MIN : ENT_W'(-div_item.lane[k].lq);
         end else begin
            sat[k] = div_item.lane[k].ovf || div_item.lane[k].lq[ENT_W-1];
            rsp_tdata_in[k*ENT_W +: ENT_W] = sat[k] ? POS_MAX : div_item.lane[k].lq;
         end
      end
      rsp_tuser_in[USER_SINGULAR] = div_item.singular;
      rsp_tuser_in[USER_SAT]      = |sat;
      if (div_item.singular) begin
         rsp_tdata_in           = '0;
         rsp_tuser_in[USER_SAT] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_tvalid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready && div_valid) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== rtl/core/mia_checker.sv =====
`include "matrix3x3_inverse_adjugate_top_defines.svh"

module mia_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mia_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   input logic [mia_pkg::USER_W-1:0]      rsp_tuser
);
   import mia_pkg::*;

   logic sing_beat;
   logic sing_clean;
   logic stall;

   assign sing_beat  = rsp_tvalid && rsp_tuser[USER_SINGULAR];
   assign sing_clean = (rsp_tdata == '0) && !rsp_tuser[USER_SAT];
   assign stall      = rsp_tvalid && !rsp_tready;

   `MIA_ASSERT_NEXT_RST(a_reset_idle, clock, reset, !rsp_tvalid)
   `MIA_ASSERT_SAME(a_singular_zero, clock, reset, sing_beat, sing_clean)
   `MIA_ASSERT_NEXT(a_hold_valid, clock, reset, stall, rsp_tvalid)
   `MIA_ASSERT_NEXT(a_hold_beat, clock, reset, stall, $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind matrix3x3_inverse_adjugate_top mia_checker u_mia_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mia_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 1750;
   localparam int LATENCY     = 41;

   typedef struct {
      mat_type inv;
      logic    singular;
      logic    saturated;
   } inverse_type;

   typedef struct {
      mat_type     m;
      bit          typed;
      inverse_type want;
   } vector_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [USER_W-1:0]     rsp_tuser;

   inverse_type pending_inverses[$];
   vector_type  vectors[$];
   int          failures;
   int          cycles;
   int          results_seen;
   bit          hold_off_req;

   matrix3x3_inverse_adjugate_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic inverse_type invert_matrix(mat_type m);
      logic signed [63:0]  x[9];
      logic signed [63:0]  c[9];
      logic signed [127:0] det, e0, e1, e2, c0, c1, c2;
      logic [127:0]        dmag, num, q;
      logic [63:0]         cm;
      logic                dneg, neg;
      inverse_type         r;
      for (int k = 0; k < 9; k++) x[k] = m[k];
      c[0] = x[4] * x[8] - x[5] * x[7];
      c[1] = x[5] * x[6] - x[3] * x[8];
      c[2] = x[3] * x[7] - x[4] * x[6];
      c[3] = x[2] * x[7] - x[1] * x[8];
      c[4] = x[0] * x[8] - x[2] * x[6];
      c[5] = x[1] * x[6] - x[0] * x[7];
      c[6] = x[1] * x[5] - x[2] * x[4];
      c[7] = x[2] * x[3] - x[0] * x[5];
      c[8] = x[0] * x[4] - x[1] * x[3];
      e0 = x[0]; e1 = x[1]; e2 = x[2];
      c0 = c[0]; c1 = c[1]; c2 = c[2];
      det = e0 * c0 + e1 * c1 + e2 * c2;
      r.inv = '0;
      r.saturated = 1'b0;
      r.singular = (det == 0);
      if (r.singular) return r;
      dneg = det < 0;
      dmag = dneg ? -det : det;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            neg = (c[j*3+i] < 0) != dneg;
            cm = c[j*3+i] < 0 ? -c[j*3+i] : c[j*3+i];
            num = {64'd0, cm} << (2 * FRAC_BITS);
            q = num / dmag;
            if (!neg) begin
               if (q > 128'h7FFFFFFF) begin
                  r.inv[i*3+j] = POS_MAX;
                  r.saturated = 1'b1;
               end else begin
                  r.inv[i*3+j] = q[31:0];
               end
            end else begin
               if (q > 128'h80000000) begin
                  r.inv[i*3+j] = NEG_MIN;
                  r.saturated = 1'b1;
               end else begin
                  r.inv[i*3+j] = -q[31:0];
               end
            end
         end
      end
      return r;
   endfunction

   function automatic mat_type diag(ent_type d, ent_type off);
      mat_type m;
      for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? d : off;
      return m;
   endfunction

   function automatic ent_type rand_entry();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3:       return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
         4:       return $signed($urandom_range(0, 8)) - 4;
         default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      endcase
   endfunction

   function automatic mat_type rand_matrix();
      mat_type m;
      int      src, dst;
      for (int k = 0; k < 9; k++) m[k] = rand_entry();
      if ($urandom_range(0, 9) == 0) begin
         src = $urandom_range(0, 2);
         dst = (src + $urandom_range(1, 2)) % 3;
         for (int j = 0; j < 3; j++) m[dst*3+j] = m[src*3+j];
      end
      return m;
   endfunction

   task automatic add_typed(mat_type m, mat_type inv, logic sing, logic sat);
      vector_type v;
      v.m = m;
      v.typed = 1'b1;
      v.want.inv = inv;
      v.want.singular = sing;
      v.want.saturated = sat;
      vectors.push_back(v);
   endtask

   task automatic add_predicted(mat_type m);
      vector_type v;
      v.m = m;
      v.typed = 1'b0;
      vectors.push_back(v);
   endtask

   task automatic build_vectors();
      mat_type m;
      add_typed('0, '0, 1'b1, 1'b0);
      add_typed(diag(32'sh10000, 0), diag(32'sh10000, 0), 1'b0, 1'b0);
      add_typed(diag(32'sh20000, 0), diag(32'sh8000, 0), 1'b0, 1'b0);
      add_typed(diag(1, 0), diag(POS_MAX, 0), 1'b0, 1'b1);
      add_typed(diag(-1, 0), diag(NEG_MIN, 0), 1'b0, 1'b1);
      add_typed({9{POS_MAX}}, '0, 1'b1, 1'b0);
      add_typed({9{NEG_MIN}}, '0, 1'b1, 1'b0);
      add_predicted(diag(NEG_MIN, 0));
      add_predicted(diag(POS_MAX, 0));
      add_predicted(diag(POS_MAX, NEG_MIN));
      add_predicted(diag(NEG_MIN, POS_MAX));
      add_predicted(diag(32'sh10000, 32'sh8000));
      m = '0;
      m[1] = 32'sh10000; m[5] = -32'sh10000; m[6] = 32'sh30000;
      add_predicted(m);
      m = {32'sh1234567, -32'sh89ABC, 32'sh7FFF0000, 32'sh1, -32'sh55555555,
           32'sh2AAAAAAA, -32'sh1, 32'sh10000, 32'sh55AA};
      add_predicted(m);
      add_predicted(~m);
      for (int k = 0; k < N_RANDOM; k++) add_predicted(rand_matrix());
   endtask

   task automatic drive_matrices();
      vector_type v;
      int         burst;
      burst = 0;
      for (int n = 0; n < vectors.size(); n++) begin
         v = vectors[n];
         if (n == 900) begin
            req_tvalid <= 1'b0;
            while (pending_inverses.size() != 0) @(posedge clock);
         end else if (burst <= 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         burst--;
         req_tvalid <= 1'b1;
         req_tdata <= v.m;
         do @(negedge clock); while (!req_tready);
         @(posedge clock);
         pending_inverses.push_back(v.typed ? v.want : invert_matrix(v.m));
      end
      req_tvalid <= 1'b0;
   endtask

   // receiver stall pattern with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_req) begin
         rsp_tready <= 1'b0;
      end else begin
         case ((cycles / 64) % 4)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 3) != 0;
            2:       rsp_tready <= (cycles % 5) < 2;
            default: rsp_tready <= $urandom_range(0, 1);
         endcase
      end
   end

   initial begin
      hold_off_req = 1'b0;
      wait (results_seen >= 300);
      hold_off_req = 1'b1;
      repeat (300) @(posedge clock);
      hold_off_req = 1'b0;
   end

   always @(negedge clock) begin
      inverse_type want;
      mat_type     got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got = rsp_tdata;
         if (pending_inverses.size() == 0) begin
            $error("result beat with no expectation");
            failures++;
         end else begin
            want = pending_inverses.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (got[k] !== want.inv[k]) begin
                  $error("inv%0d%0d: expected %h, actual %h", k / 3, k % 3,
                         want.inv[k], got[k]);
                  failures++;
               end
            end
            if (rsp_tuser[USER_SINGULAR] !== want.singular) begin
               $error("singular: expected %b, actual %b", want.singular,
                      rsp_tuser[USER_SINGULAR]);
               failures++;
            end
            if (rsp_tuser[USER_SAT] !== want.saturated) begin
               $error("saturated: expected %b, actual %b", want.saturated,
                      rsp_tuser[USER_SAT]);
               failures++;
            end
         end
      end
   end

   initial begin
      failures = 0;
      cycles = 0;
      results_seen = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      build_vectors();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drive_matrices();
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (failures == 0 && pending_inverses.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
